>>> hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Condition that must never hold outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) else $error(msg);

`endif

>>> hw/rtl/chte_pkg.sv
package chte_pkg;

  localparam int unsigned KEY_W     = 64;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned ENTRY_W   = 11;
  localparam int unsigned CAPACITY  = 1024;
  localparam int unsigned ADDR_W    = 10;
  localparam int unsigned HEAD_BITS = 8;
  localparam int unsigned NUM_HEADS = 256;
  localparam int unsigned BB_W      = 4;

  typedef enum logic {
    CMD_PUT  = 1'b0,
    CMD_FIND = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    MODE_OVERWRITE = 2'd0,
    MODE_ERROR     = 2'd1,
    MODE_IGNORE    = 2'd2,
    MODE_COPY      = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_DUP  = 2'd1,
    STAT_FULL = 2'd2,
    STAT_RSVD = 2'd3
  } status_e;

  typedef struct packed {
    cmd_e                cmd;
    logic [KEY_W-1:0]    key;
    logic [DATA_W-1:0]   data_in;
    mode_e               collision_mode;
    logic [ENTRY_W-1:0]  start_entry;
  } in_t;

  typedef struct packed {
    logic                found;
    logic [DATA_W-1:0]   data_out;
    logic [ENTRY_W-1:0]  next_entry;
    status_e             status;
  } out_t;

endpackage

>>> hw/rtl/chte_ram.sv
module chte_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/chained_hash_table_engine.sv
// Channel | Signals                          | Direction | Moves
// --------+----------------------------------+-----------+----------------------------
// in      | in_valid_i, in_stall_o, in_i     | to block  | one put/find item
// out     | out_valid_o, out_stall_i, out_o  | from block| one result item per input
// cfg     | cfg_valid_i, cfg_ready_o, cfg_data_i | to block | bucket_bits register
//
// Steps: accept, head read, a look and a compare per chain entry, a last look when the
//   walk runs off the chain end, an update for every put, a link write when a new entry
//   links behind another, then the result load; a resumed find skips the head read.
// Reset: bucket heads read empty at once through per-bucket valid bits; no clearing pass.
// Stalls: a finished result waits in the output register; the next item is taken
//   and walked meanwhile and only its final hand-off waits for out_stall_i low.
`include "assert_macros.svh"

module chained_hash_table_engine (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  chte_pkg::in_t                      in_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output chte_pkg::out_t                     out_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [chte_pkg::BB_W-1:0]          cfg_data_i
);
  import chte_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_HEAD = 7'b0000010,
    ST_LOOK = 7'b0000100,
    ST_CMP  = 7'b0001000,
    ST_UPD  = 7'b0010000,
    ST_LINK = 7'b0100000,
    ST_DONE = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic [BB_W-1:0]      bb_q;
  in_t                  item_q, item_d;
  logic [HEAD_BITS-1:0] bucket_q, bucket_d, bucket_in;
  logic [ENTRY_W-1:0]   cur_q, cur_d;
  logic [ENTRY_W-1:0]   prev_q, prev_d;
  logic [ENTRY_W-1:0]   steps_q, steps_d;
  logic [ENTRY_W-1:0]   used_q, used_d;
  logic                 hit_q, hit_d;
  out_t                 res_q, res_d;
  out_t                 out_q, out_d;
  logic                 out_valid_q, out_valid_d;
  logic [NUM_HEADS-1:0] hv_q, hv_d;

  // memory ports
  logic                 head_we;
  logic [ENTRY_W-1:0]   head_rd;
  logic                 key_we, val_we, link_we;
  logic [ADDR_W-1:0]    key_wa, val_wa, link_wa, ent_ra;
  logic [DATA_W-1:0]    val_wd, val_rd;
  logic [ENTRY_W-1:0]   link_wd, link_rd;
  logic [KEY_W-1:0]     key_rd;

  // bucket select: top 32 key bits masked to min(bucket_bits, HEAD_BITS)
  logic [BB_W-1:0]      bb_eff;
  logic [HEAD_BITS:0]   bmask;
  assign bb_eff    = (bb_q > BB_W'(HEAD_BITS)) ? BB_W'(HEAD_BITS) : bb_q;
  assign bmask     = (HEAD_BITS+1)'((1 << bb_eff) - 1);
  assign bucket_in = in_i.key[KEY_W-32 +: HEAD_BITS] & bmask[HEAD_BITS-1:0];

  logic cur_ok, in_acc, out_free;
  assign cur_ok   = (cur_q != '0) && (cur_q <= used_q);
  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign ent_ra   = ADDR_W'(cur_q - ENTRY_W'(1));

  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    bucket_d    = bucket_q;
    cur_d       = cur_q;
    prev_d      = prev_q;
    steps_d     = steps_q;
    used_d      = used_q;
    hit_d       = hit_q;
    res_d       = res_q;
    out_d       = out_q;
    hv_d        = hv_q;
    out_valid_d = out_valid_q && out_stall_i;
    head_we     = 1'b0;
    key_we      = 1'b0;
    val_we      = 1'b0;
    link_we     = 1'b0;
    key_wa      = ADDR_W'(used_q);
    val_wa      = ADDR_W'(used_q);
    link_wa     = ADDR_W'(used_q);
    val_wd      = item_q.data_in;
    link_wd     = cur_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          item_d   = in_i;
          bucket_d = bucket_in;
          hit_d    = 1'b0;
          prev_d   = '0;
          steps_d  = '0;
          res_d    = '{found: 1'b0, data_out: '0, next_entry: '0, status: STAT_OK};
          if (in_i.cmd == CMD_FIND && in_i.start_entry != '0) begin
            cur_d   = in_i.start_entry;
            // start beyond the filled entries answers as a miss
            state_d = (in_i.start_entry > used_q) ? ST_DONE : ST_LOOK;
          end else begin
            state_d = ST_HEAD;
          end
        end
      end
      ST_HEAD: begin
        cur_d   = hv_q[bucket_q] ? head_rd : '0;
        state_d = ST_LOOK;
      end
      ST_LOOK: begin
        if (cur_ok) begin
          state_d = ST_CMP;
        end else begin
          state_d = (item_q.cmd == CMD_FIND) ? ST_DONE : ST_UPD;
        end
      end
      ST_CMP: begin
        if (item_q.key == key_rd) begin
          hit_d = 1'b1;
          if (item_q.cmd == CMD_FIND) begin
            res_d.found      = 1'b1;
            res_d.data_out   = val_rd;
            res_d.next_entry = link_rd;
            state_d          = ST_DONE;
          end else begin
            state_d = ST_UPD;
          end
        end else if (item_q.key > key_rd || steps_q == ENTRY_W'(CAPACITY)) begin
          state_d = (item_q.cmd == CMD_FIND) ? ST_DONE : ST_UPD;
        end else begin
          steps_d = steps_q + ENTRY_W'(1);
          prev_d  = cur_q;
          cur_d   = link_rd;
          state_d = ST_LOOK;
        end
      end
      ST_UPD: begin
        res_d.found = hit_q;
        state_d     = ST_DONE;
        if (hit_q && item_q.collision_mode == MODE_OVERWRITE) begin
          val_we = 1'b1;
          val_wa = ent_ra;
        end else if (hit_q && item_q.collision_mode == MODE_ERROR) begin
          res_d.status = STAT_DUP;
        end else if (hit_q && item_q.collision_mode == MODE_IGNORE) begin
          res_d.status = STAT_OK;
        end else if (used_q >= ENTRY_W'(CAPACITY)) begin
          res_d.status = STAT_FULL;
        end else begin
          // new entry takes the next free number, linked ahead of cur
          key_we  = 1'b1;
          val_we  = 1'b1;
          link_we = 1'b1;
          used_d  = used_q + ENTRY_W'(1);
          if (prev_q != '0) begin
            state_d = ST_LINK;
          end else begin
            head_we          = 1'b1;
            hv_d[bucket_q]   = 1'b1;
          end
        end
      end
      ST_LINK: begin
        link_we = 1'b1;
        link_wa = ADDR_W'(prev_q - ENTRY_W'(1));
        link_wd = used_q;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      bb_q        <= BB_W'(HEAD_BITS);
      used_q      <= '0;
      hv_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      hv_q        <= hv_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        bb_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    item_q   <= item_d;
    bucket_q <= bucket_d;
    cur_q    <= cur_d;
    prev_q   <= prev_d;
    steps_q  <= steps_d;
    hit_q    <= hit_d;
    res_q    <= res_d;
    out_q    <= out_d;
  end

  chte_ram #(.WIDTH(ENTRY_W), .DEPTH(NUM_HEADS)) u_heads (
    .clk_i  (clk_i),
    .we_i   (head_we),
    .waddr_i(bucket_q),
    .wdata_i(used_d),
    .raddr_i(bucket_in),
    .rdata_o(head_rd)
  );

  chte_ram #(.WIDTH(KEY_W), .DEPTH(CAPACITY)) u_keys (
    .clk_i  (clk_i),
    .we_i   (key_we),
    .waddr_i(key_wa),
    .wdata_i(item_q.key),
    .raddr_i(ent_ra),
    .rdata_o(key_rd)
  );

  chte_ram #(.WIDTH(DATA_W), .DEPTH(CAPACITY)) u_vals (
    .clk_i  (clk_i),
    .we_i   (val_we),
    .waddr_i(val_wa),
    .wdata_i(val_wd),
    .raddr_i(ent_ra),
    .rdata_o(val_rd)
  );

  chte_ram #(.WIDTH(ENTRY_W), .DEPTH(CAPACITY)) u_links (
    .clk_i  (clk_i),
    .we_i   (link_we),
    .waddr_i(link_wa),
    .wdata_i(link_wd),
    .raddr_i(ent_ra),
    .rdata_o(link_rd)
  );

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;
  assign cfg_ready_o = 1'b1;

  `ASSERT_NEVER(a_used_max, clk_i, rst_ni, used_q > ENTRY_W'(CAPACITY), "entry count overflow")
  `ASSERT_CLK(a_cmp_valid, clk_i, rst_ni, state_q == ST_CMP |-> cur_ok, "bad compare entry")
  `ASSERT_CLK(a_done_out, clk_i, rst_ni, state_q == ST_DONE && out_free |=> out_valid_q, "lost")
  `ASSERT_CLK(a_used_step, clk_i, rst_ni, $changed(used_q) |-> used_q == $past(used_q) + 1'b1, "jump")

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import chte_pkg::*;

  // The hash table is modeled directly in the test bench with fixed-size
  // arrays.  Each chain is kept in non-increasing key order, and entry 0
  // means "no entry".
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 64;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  in_t  in_i;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_t out_o;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [BB_W-1:0] cfg_data_i;

  always #5 clk_i = ~clk_i;

  chained_hash_table_engine dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_i(in_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_o(out_o),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o), .cfg_data_i(cfg_data_i)
  );

  // Shadow copy of the table.
  logic [BB_W-1:0]    tbl_bucket_bits;
  logic [ENTRY_W-1:0] tbl_heads [NUM_HEADS];
  logic [KEY_W-1:0]   tbl_keys  [CAPACITY+1];
  logic [DATA_W-1:0]  tbl_vals  [CAPACITY+1];
  logic [ENTRY_W-1:0] tbl_links [CAPACITY+1];
  int unsigned        tbl_used;

  out_t        expected_results[$];
  int          mismatch_count = 0;
  int          idle_cycles = 0;
  bit          stall_storm;       // receiver stalls heavily while set
  logic [KEY_W-1:0] key_pool[$];  // keys already stored, for hits

  function automatic int unsigned bucket_of(logic [KEY_W-1:0] key);
    int unsigned bb;
    bb = (tbl_bucket_bits > HEAD_BITS) ? HEAD_BITS : tbl_bucket_bits;
    return key[KEY_W-1 -: 32] & ((32'd1 << bb) - 1);
  endfunction

  function automatic bit entry_ok(int unsigned e);
    return e >= 1 && e <= tbl_used;
  endfunction

  // Chain walk: stops on an equal key, on the first smaller key, or at the chain end.
  // Returns 1 on a hit; at is the hit entry, prv the last larger entry.
  function automatic bit chain_walk(logic [KEY_W-1:0] key, int unsigned first,
                                    output int unsigned at, output int unsigned prv);
    int unsigned cur;
    int unsigned steps;
    cur = first; prv = 0; steps = 0; at = 0;
    while (entry_ok(cur)) begin
      if (key == tbl_keys[cur]) begin
        at = cur;
        return 1'b1;
      end
      if (key > tbl_keys[cur]) break;
      steps++;
      if (steps > CAPACITY) begin
        cur = 0;
        break;
      end
      prv = cur;
      cur = tbl_links[cur];
    end
    at = cur;
    return 1'b0;
  endfunction

  function automatic out_t table_apply(in_t it);
    out_t r;
    int unsigned at, prv, b, fresh;
    bit hit;
    r = '0;
    b = bucket_of(it.key);
    if (it.cmd == CMD_FIND) begin
      if (it.start_entry != 0 && !entry_ok(it.start_entry)) return r;
      hit = chain_walk(it.key, (it.start_entry != 0) ? it.start_entry : tbl_heads[b], at, prv);
      if (hit) begin
        r.found = 1'b1;
        r.data_out = tbl_vals[at];
        r.next_entry = tbl_links[at];
      end
      return r;
    end
    hit = chain_walk(it.key, tbl_heads[b], at, prv);
    r.found = hit;
    if (hit && it.collision_mode == MODE_OVERWRITE) begin
      tbl_vals[at] = it.data_in;
      return r;
    end
    if (hit && it.collision_mode == MODE_ERROR) begin
      r.status = STAT_DUP;
      return r;
    end
    if (hit && it.collision_mode == MODE_IGNORE) return r;
    if (tbl_used >= CAPACITY) begin
      r.status = STAT_FULL;
      return r;
    end
    fresh = tbl_used + 1;
    tbl_keys[fresh] = it.key;
    tbl_vals[fresh] = it.data_in;
    if (prv != 0) begin
      tbl_links[fresh] = tbl_links[prv];
      tbl_links[prv] = fresh;
    end else begin
      tbl_links[fresh] = tbl_heads[b];
      tbl_heads[b] = fresh;
    end
    tbl_used = fresh;
    key_pool.push_back(it.key);
    return r;
  endfunction

  // Result checker: every accepted result against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("ERROR: unexpected result %p", out_o);
      end else begin
        out_t exp_r;
        exp_r = expected_results.pop_front();
        if (out_o.found !== exp_r.found || out_o.data_out !== exp_r.data_out ||
            out_o.next_entry !== exp_r.next_entry || out_o.status !== exp_r.status) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display({"ERROR: result mismatch exp found=%0d data=%h next=%0d st=%0d,",
                      " got found=%0d data=%h next=%0d st=%0d"},
                     exp_r.found, exp_r.data_out, exp_r.next_entry, exp_r.status,
                     out_o.found, out_o.data_out, out_o.next_entry, out_o.status);
        end
      end
    end
  end

  // Receiver stall pattern: runs of free flow, random stalls, and storms.
  int stall_phase = 0;
  always @(negedge clk_i) begin
    stall_phase <= stall_phase + 1;
    if (!rst_ni) out_stall_i <= 1'b0;
    else if (stall_storm) out_stall_i <= ($urandom_range(0, 3) != 0);
    else if ((stall_phase / 200) % 3 == 0) out_stall_i <= 1'b0;
    else out_stall_i <= ($urandom_range(0, 3) == 0);
  end

  // Watchdog: cycles with no handshake on any channel.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_LIMIT) begin
      $display("chained_hash_table_engine verification failed");
      $finish;
    end
  end

  // Sender burst control.
  int burst_left;

  task automatic send_item(in_t it);
    // valid is already low here whenever the burst has run out
    if (burst_left <= 0) begin
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
      burst_left = $urandom_range(1, 30);
    end
    in_i <= it;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_results.push_back(table_apply(it));
    burst_left--;
    @(negedge clk_i);
    // valid stays high if another item follows right away
    if (burst_left <= 0) in_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    if (burst_left > 0) in_valid_i <= 1'b0;
    burst_left = 0;
    while (expected_results.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_bucket_bits(logic [BB_W-1:0] v);
    cfg_data_i <= v;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    tbl_bucket_bits = v;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic in_t make_item(cmd_e c, logic [KEY_W-1:0] k, logic [DATA_W-1:0] d,
                                    mode_e m, logic [ENTRY_W-1:0] s);
    in_t it;
    it.cmd = c; it.key = k; it.data_in = d; it.collision_mode = m; it.start_entry = s;
    return it;
  endfunction

  function automatic logic [KEY_W-1:0] rand_key();
    logic [KEY_W-1:0] k;
    k = {$urandom, $urandom};
    // bias toward few buckets and repeated keys so chains grow long
    case ($urandom_range(0, 3))
      0: k[KEY_W-1 -: 32] = $urandom_range(0, 3);
      1: if (key_pool.size() != 0) k = key_pool[$urandom_range(0, key_pool.size() - 1)];
      default: ;
    endcase
    return k;
  endfunction

  function automatic in_t rand_item();
    in_t it;
    logic [ENTRY_W-1:0] s;
    s = ($urandom_range(0, 2) == 0) ? ENTRY_W'(0) :
        (($urandom_range(0, 7) == 0) ? ENTRY_W'($urandom_range(0, 2047)) :
                                       ENTRY_W'($urandom_range(1, tbl_used + 1)));
    it = make_item(cmd_e'($urandom_range(0, 1)), rand_key(), $urandom,
                   mode_e'($urandom_range(0, 3)), s);
    return it;
  endfunction

  // Directed: edge keys, every mode, start entries, out-of-range start.
  task automatic test_directed();
    logic [KEY_W-1:0] k;
    k = 64'h0000_0005_0000_0000;
    send_item(make_item(CMD_FIND, k, '0, MODE_OVERWRITE, '0));             // empty miss
    send_item(make_item(CMD_PUT, k, 32'hFFFF_FFFF, MODE_OVERWRITE, '0));
    send_item(make_item(CMD_PUT, k + 10, 32'h1, MODE_OVERWRITE, '0));     // larger: head
    send_item(make_item(CMD_PUT, k + 5, 32'h2, MODE_OVERWRITE, '0));      // middle link
    send_item(make_item(CMD_PUT, k - 1, 32'h3, MODE_OVERWRITE, '0));      // head of another bucket
    send_item(make_item(CMD_PUT, k, 32'hAAAA_5555, MODE_OVERWRITE, '0));  // overwrite
    send_item(make_item(CMD_PUT, k, 32'h5, MODE_ERROR, '0));              // duplicate
    send_item(make_item(CMD_PUT, k, 32'h6, MODE_IGNORE, '0));
    send_item(make_item(CMD_PUT, k, 32'h7, MODE_COPY, '0));               // second copy
    send_item(make_item(CMD_FIND, k, '0, MODE_OVERWRITE, '0));
    send_item(make_item(CMD_FIND, k, '0, MODE_OVERWRITE, 11'd5));         // resume at copy
    send_item(make_item(CMD_FIND, k, '0, MODE_OVERWRITE, 11'd2047));      // start out of range
    send_item(make_item(CMD_FIND, k, '0, MODE_OVERWRITE, 11'd6));         // one past used
    send_item(make_item(CMD_PUT, '0, '0, MODE_COPY, 11'h7FF));
    send_item(make_item(CMD_PUT, '1, '1, MODE_ERROR, '0));
    send_item(make_item(CMD_FIND, '1, '1, MODE_COPY, '0));
    send_item(make_item(CMD_FIND, '0, '0, MODE_IGNORE, '0));
    send_item(make_item(CMD_FIND, k - 2, '0, MODE_OVERWRITE, '0));        // miss at chain end
    wait_drained();
  endtask

  task automatic test_random(int n);
    repeat (n) send_item(rand_item());
  endtask

  // Fill the table to capacity, then probe the full behavior.
  task automatic test_full_table();
    in_t it;
    while (tbl_used < CAPACITY) begin
      it = rand_item();
      it.cmd = CMD_PUT;
      it.collision_mode = MODE_COPY;
      send_item(it);
    end
    send_item(make_item(CMD_PUT, key_pool[0], 32'h1234_5678, MODE_OVERWRITE, '0));
    send_item(make_item(CMD_PUT, key_pool[1], 32'h1, MODE_COPY, '0));
    send_item(make_item(CMD_FIND, key_pool[0], '0, MODE_OVERWRITE, '0));
    send_item(make_item(CMD_FIND, key_pool[2], '0, MODE_OVERWRITE, 11'd1024));
    test_random(20);
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_i = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    stall_storm = 1'b0;
    burst_left = 0;
    tbl_bucket_bits = 4'd8;
    tbl_used = 0;
    foreach (tbl_heads[i]) tbl_heads[i] = '0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed();
    // settings: low, none, above max, middle, max
    write_bucket_bits(4'd1);
    test_random(40);
    wait_drained();
    write_bucket_bits(4'd0);
    stall_storm = 1'b1;
    test_random(40);
    stall_storm = 1'b0;
    wait_drained();
    write_bucket_bits(4'd15);
    test_random(40);
    wait_drained();
    write_bucket_bits(4'd3);
    test_random(40);
    wait_drained();
    write_bucket_bits(4'd8);
    test_full_table();
    wait_drained();

    if (mismatch_count == 0 && expected_results.size() == 0)
      $display("chained_hash_table_engine verification clean");
    else
      $display("chained_hash_table_engine verification failed");
    $finish;
  end

endmodule
